[design/linear_interp_resampler_core_macros.svh]
// assertion helpers shared by the resampler modules
// both expect clk and rst_n in scope at the point of use
`ifndef LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define LIR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lir_pkg.sv]
package lir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 17;
  localparam int VOL_W      = 7;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_W      = 32;
  localparam int POS_W      = 17;
  localparam int SUM_W      = POS_W + 1;
  localparam int INTERP_W   = SAMPLE_W + 2;
  localparam int SCALE_W    = SAMPLE_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEREO = 2'd2;

  localparam logic [RATE_W-1:0] RATE_MIN   = 17'd8000;
  localparam logic [RATE_W-1:0] RATE_MAX   = 17'd96000;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd48000;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd80;

  localparam logic [POS_W-1:0] OUTPUT_RATE = 17'd48000;

  // |diff| * pos / 48000 as (x >> 7) / 375, reciprocal estimate plus one correction
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int DIV_SHIFT    = 7;
  localparam int DIVX_W       = PROD_W - DIV_SHIFT;
  localparam int DIV_LO_W     = 9;
  localparam logic [DIV_LO_W-1:0] DIV_LO = 9'd375;
  localparam int DIV_MUL_W    = 24;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd11453246;
  localparam int DIV_SH       = 32;
  localparam int DIV_FULL_W   = DIVX_W + DIV_MUL_W;

  // |sample| * volume / 100 as (y >> 2) / 25
  localparam int VPROD_W      = 22;
  localparam int VDIV_SHIFT   = 2;
  localparam int VDIVX_W      = VPROD_W - VDIV_SHIFT;
  localparam int VDIV_LO_W    = 5;
  localparam logic [VDIV_LO_W-1:0] VDIV_LO = 5'd25;
  localparam int VDIV_MUL_W   = 20;
  localparam logic [VDIV_MUL_W-1:0] VDIV_MUL = 20'd671088;
  localparam int VDIV_SH      = 24;
  localparam int VDIV_FULL_W  = VDIVX_W + VDIV_MUL_W;

  localparam logic signed [SCALE_W-1:0] SAT_MAX = 17'sd32767;
  localparam logic signed [SCALE_W-1:0] SAT_MIN = -17'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_MUL,
    ST_REC,
    ST_COR,
    ST_VMUL,
    ST_VREC,
    ST_EMIT
  } lir_state_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [VOL_W-1:0]  volume;
    logic              stereo;
  } lir_cfg_t;

  typedef struct packed {
    logic accept;
    logic samp_cur;
    logic skip;
    logic mul;
    logic rec;
    logic cor;
    logic vmul;
    logic vrec;
    logic emit;
  } lir_cmd_t;

  typedef struct packed {
    logic first;
    logic pos_over;
    logic last;
    logic slot_free;
  } lir_sts_t;

endpackage

[design/lir_in_if.sv]
interface lir_in_if;
  import lir_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       restart;

  modport source (output valid, output left_sample, output right_sample, output restart,
                  input ready);
  modport sink (input valid, input left_sample, input right_sample, input restart,
                output ready);
endinterface

[design/lir_out_if.sv]
interface lir_out_if;
  import lir_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_word;
  logic                    last;

  modport source (output valid, output out_word, output last, input ready);
  modport sink (input valid, input out_word, input last, output ready);
endinterface

[design/lir_cfg.sv]
module lir_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lir_pkg::CFG_W-1:0]      cfg_data,
  output lir_pkg::lir_cfg_t              cfg
);
  import lir_pkg::*;

  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [VOL_W-1:0]  vol_r, vol_nxt;
  logic              stereo_r, stereo_nxt;
  logic [VOL_W-1:0]  vol_in;

  assign vol_in = cfg_data[VOL_W-1:0];

  always_comb begin
    rate_nxt   = rate_r;
    vol_nxt    = vol_r;
    stereo_nxt = stereo_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_RATE: begin
          if (cfg_data >= RATE_MIN && cfg_data <= RATE_MAX) begin
            rate_nxt = cfg_data[RATE_W-1:0];
          end
        end
        CFG_IDX_VOLUME: begin
          vol_nxt = (vol_in > VOL_MAX) ? VOL_MAX : vol_in;
        end
        CFG_IDX_STEREO: begin
          stereo_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= RATE_RESET;
      vol_r    <= VOL_RESET;
      stereo_r <= 1'b0;
    end else begin
      rate_r   <= rate_nxt;
      vol_r    <= vol_nxt;
      stereo_r <= stereo_nxt;
    end
  end

  assign cfg.rate   = rate_r;
  assign cfg.volume = vol_r;
  assign cfg.stereo = stereo_r;

endmodule

[design/lir_ctrl.sv]
`include "linear_interp_resampler_core_macros.svh"

module lir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lir_pkg::lir_sts_t sts,
  output lir_pkg::lir_cmd_t cmd
);
  import lir_pkg::*;

  lir_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.first) begin
          cmd.samp_cur = 1'b1;
          state_nxt    = ST_VMUL;
        end else if (sts.pos_over) begin
          cmd.skip  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_REC;
      end
      ST_REC: begin
        cmd.rec   = 1'b1;
        state_nxt = ST_COR;
      end
      ST_COR: begin
        cmd.cor   = 1'b1;
        state_nxt = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.vmul  = 1'b1;
        state_nxt = ST_VREC;
      end
      ST_VREC: begin
        cmd.vrec  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LIR_ASSERT_NXT(a_fire_to_chk, in_valid && in_ready, state_r == ST_CHK, "accept did not start check")
  `LIR_ASSERT_NXT(a_last_to_idle, cmd.emit && sts.last, in_ready, "final result did not free input")
  `LIR_ASSERT_NXT(a_loop_to_mul, cmd.emit && !sts.last, cmd.mul, "interpolation loop broken")

endmodule

[design/lir_dp.sv]
`include "linear_interp_resampler_core_macros.svh"

module lir_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lir_pkg::lir_cmd_t                  cmd,
  input  lir_pkg::lir_cfg_t                  cfg,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                               in_restart,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [lir_pkg::OUT_W-1:0]   out_word,
  output logic                               out_last,
  output lir_pkg::lir_sts_t                  sts
);
  import lir_pkg::*;

  logic                       have_prev_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic                       first_r;
  logic [POS_W-1:0]           pos_r;
  logic [PROD_W-1:0]          prod_r;
  logic                       neg_r;
  logic [SAMPLE_W-1:0]        q0_r;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic [VPROD_W-1:0]         vprod_r;
  logic                       vneg_r;
  logic [SAMPLE_W-1:0]        vq0_r;
  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_word_r;
  logic                       out_last_r;

  // input frame to mono, halving rounds toward zero
  logic signed [SAMPLE_W:0]   in_sum;
  logic signed [SAMPLE_W:0]   in_sum_adj;
  logic signed [SAMPLE_W-1:0] in_cur;

  assign in_sum     = {in_left_sample[SAMPLE_W-1], in_left_sample}
                    + {in_right_sample[SAMPLE_W-1], in_right_sample};
  assign in_sum_adj = in_sum + {{SAMPLE_W{1'b0}}, in_sum[SAMPLE_W]};
  assign in_cur     = cfg.stereo ? in_sum_adj[SAMPLE_W:1] : in_left_sample;

  // interpolation step
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        abs_diff;
  logic [PROD_W-1:0]          prod_nxt;
  logic [DIVX_W-1:0]          div_x;
  logic [DIV_FULL_W-1:0]      rec_full;
  logic [DIVX_W-1:0]          lo_rem;
  logic [SAMPLE_W-1:0]        q;
  logic signed [INTERP_W-1:0] q_signed;
  logic signed [INTERP_W-1:0] interp;

  assign diff     = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign abs_diff = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
  assign prod_nxt = abs_diff * pos_r[SAMPLE_W-1:0];
  assign div_x    = prod_r[PROD_W-1:DIV_SHIFT];
  assign rec_full = div_x * DIV_MUL;
  assign lo_rem   = div_x - q0_r * DIV_LO;
  assign q        = q0_r + SAMPLE_W'(lo_rem >= DIVX_W'(DIV_LO));
  assign q_signed = neg_r ? -INTERP_W'(q) : INTERP_W'(q);
  assign interp   = INTERP_W'(prev_r) + q_signed;

  // volume scaling
  logic [SAMPLE_W-1:0]        abs_samp;
  logic [VPROD_W-1:0]         vprod_nxt;
  logic [VDIVX_W-1:0]         vdiv_x;
  logic [VDIV_FULL_W-1:0]     vrec_full;
  logic [VDIVX_W-1:0]         vrem;
  logic [SAMPLE_W-1:0]        vq;
  logic signed [SCALE_W-1:0]  scaled;
  logic signed [SAMPLE_W-1:0] sat;

  assign abs_samp  = samp_r[SAMPLE_W-1] ? SAMPLE_W'(-samp_r) : samp_r;
  assign vprod_nxt = abs_samp * cfg.volume;
  assign vdiv_x    = vprod_r[VPROD_W-1:VDIV_SHIFT];
  assign vrec_full = vdiv_x * VDIV_MUL;
  assign vrem      = vdiv_x - vq0_r * VDIV_LO;
  assign vq        = vq0_r + SAMPLE_W'(vrem >= VDIVX_W'(VDIV_LO));
  assign scaled    = vneg_r ? -SCALE_W'(vq) : SCALE_W'(vq);

  always_comb begin
    if (scaled > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (scaled < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = scaled[SAMPLE_W-1:0];
    end
  end

  // phase accumulator
  logic [SUM_W-1:0] pos_sum;
  logic             last_out;

  assign pos_sum  = {1'b0, pos_r} + {1'b0, cfg.rate};
  assign last_out = first_r || (pos_sum > SUM_W'(OUTPUT_RATE));

  assign sts.first     = first_r;
  assign sts.pos_over  = pos_r > OUTPUT_RATE;
  assign sts.last      = last_out;
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        have_prev_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r   <= in_cur;
      first_r <= in_restart || !have_prev_r;
    end
    if (cmd.skip) begin
      prev_r <= cur_r;
      pos_r  <= pos_r - OUTPUT_RATE;
    end
    if (cmd.samp_cur) begin
      samp_r <= cur_r;
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      neg_r  <= diff[SAMPLE_W];
    end
    if (cmd.rec) begin
      q0_r <= rec_full[DIV_SH+SAMPLE_W-1:DIV_SH];
    end
    if (cmd.cor) begin
      samp_r <= interp[SAMPLE_W-1:0];
    end
    if (cmd.vmul) begin
      vprod_r <= vprod_nxt;
      vneg_r  <= samp_r[SAMPLE_W-1];
    end
    if (cmd.vrec) begin
      vq0_r <= vrec_full[VDIV_SH+SAMPLE_W-1:VDIV_SH];
    end
    if (cmd.emit) begin
      out_word_r <= {sat, {SAMPLE_W{1'b0}}};
      out_last_r <= last_out;
      if (first_r) begin
        pos_r  <= cfg.rate;
        prev_r <= cur_r;
      end else if (last_out) begin
        pos_r  <= POS_W'(pos_sum - SUM_W'(OUTPUT_RATE));
        prev_r <= cur_r;
      end else begin
        pos_r <= pos_sum[POS_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  `LIR_ASSERT_IMP(a_div_bound, cmd.cor, lo_rem < (DIVX_W'(DIV_LO) + DIVX_W'(DIV_LO)), "interp quotient estimate off by more than one")
  `LIR_ASSERT_IMP(a_vdiv_bound, cmd.emit, vrem < (VDIVX_W'(VDIV_LO) + VDIVX_W'(VDIV_LO)), "volume quotient estimate off by more than one")
  `LIR_ASSERT_IMP(a_pos_range, have_prev_r, pos_r != '0 && pos_r <= RATE_MAX, "phase accumulator out of range")

endmodule

[design/linear_interp_resampler_core.sv]
// channel   dir  handshake             payload
// in_ch     in   valid/ready           left_sample, right_sample, restart
// out_ch    out  valid/ready           out_word, last
// cfg_*     in   cfg_we, no wait       cfg_index, cfg_data
//
// first frame of a stream: accept, check, volume multiply, volume reciprocal, emit
// otherwise accept and check, then per result (none when the phase is past the frame) the six-step
// multiply / reciprocal divide / volume scale sequence in lir_dp
// results go through one output register; a stall holds only the final step
// synchronous active-low reset clears the state machine, history and config
`include "linear_interp_resampler_core_macros.svh"

module linear_interp_resampler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  lir_in_if.sink                        in_ch,
  lir_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lir_pkg::CFG_W-1:0]     cfg_data
);
  import lir_pkg::*;

  lir_cfg_t cfg;
  lir_cmd_t cmd;
  lir_sts_t sts;
  logic     in_ready;

  lir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_left_sample  (in_ch.left_sample),
    .in_right_sample (in_ch.right_sample),
    .in_restart      (in_ch.restart),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_word        (out_ch.out_word),
    .out_last        (out_ch.last),
    .sts             (sts)
  );

  assign in_ch.ready = in_ready;

  `LIR_ASSERT_IMP(a_no_accept_busy, in_ch.valid && in_ready, !cmd.emit, "accept during emit")

endmodule

[tb/sv/tb_linear_interp_resampler_core.sv]
`timescale 1ns / 100ps

module tb_linear_interp_resampler_core;
  import lir_pkg::*;

  localparam int FRAME_WORDS_MAX  = 6;
  localparam int STALL_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 12;
  localparam int PHASE_FRAMES     = 30;
  localparam int BURST_FRAMES     = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct {
    logic [OUT_W-1:0] word;
    logic             last;
  } out_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lir_in_if  in_ch();
  lir_out_if out_ch();

  linear_interp_resampler_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // resampler state mirrored by the predictor
  int rate_setting;
  int volume_setting;
  bit stereo_setting;
  bit have_history;
  int history_sample;
  int phase_pos;

  out_beat_t expected_beats[$];

  int mismatches;
  int frames_sent;
  int words_checked;
  int cfg_writes;
  int idle_cycles;
  bit send_gaps_on;
  bit recv_gaps_on;
  int hold_request;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void reset_model();
    rate_setting   = int'(RATE_RESET);
    volume_setting = int'(VOL_RESET);
    stereo_setting = 1'b0;
    have_history   = 1'b0;
    history_sample = 0;
    phase_pos      = 0;
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_IDX_RATE: begin
        if (data >= RATE_MIN && data <= RATE_MAX) rate_setting = int'(data);
      end
      CFG_IDX_VOLUME: begin
        volume_setting = (data[VOL_W-1:0] > VOL_MAX) ? int'(VOL_MAX) : int'(data[VOL_W-1:0]);
      end
      CFG_IDX_STEREO: begin
        stereo_setting = data[0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] scaled_word(int sample);
    int v;
    v = (sample * volume_setting) / 100;
    if (v > int'(SAT_MAX)) v = int'(SAT_MAX);
    if (v < int'(SAT_MIN)) v = int'(SAT_MIN);
    return {v[15:0], 16'h0000};
  endfunction

  function automatic void predict_frame(logic signed [SAMPLE_W-1:0] left,
                                        logic signed [SAMPLE_W-1:0] right,
                                        logic restart);
    int        cur;
    longint    diff;
    int        samples[$];
    out_beat_t beat;
    cur = stereo_setting ? (int'(left) + int'(right)) / 2 : int'(left);
    if (restart || !have_history) begin
      samples.push_back(cur);
      have_history   = 1'b1;
      history_sample = cur;
      phase_pos      = rate_setting;
    end else begin
      diff = longint'(cur) - longint'(history_sample);
      while (phase_pos <= int'(OUTPUT_RATE)) begin
        if (samples.size() < FRAME_WORDS_MAX) begin
          samples.push_back(history_sample +
                            int'((diff * phase_pos) / longint'(OUTPUT_RATE)));
        end
        phase_pos += rate_setting;
      end
      phase_pos -= int'(OUTPUT_RATE);
      history_sample = cur;
    end
    foreach (samples[i]) begin
      beat.word = scaled_word(samples[i]);
      beat.last = (i == samples.size() - 1);
      expected_beats.push_back(beat);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_config(idx, data);
    cfg_writes++;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right,
                            input logic restart);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= left;
    in_ch.right_sample <= right;
    in_ch.restart      <= restart;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(left, right, restart);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    send_frame(SAMPLE_W'($urandom), SAMPLE_W'($urandom), $urandom_range(0, 24) == 0);
  endtask

  // stop offering, wait for every outstanding word, then let the core go idle
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_frame(16'sd1000, -16'sd7, 1'b0);
    send_frame(-16'sd1000, 16'sd5, 1'b0);
    send_frame(16'sd20000, 16'sd0, 1'b0);
    drain_and_settle();
  endtask

  task automatic test_sample_extremes();
    write_reg(CFG_IDX_VOLUME, 17'd100);
    write_reg(CFG_IDX_STEREO, 17'd0);
    send_frame(16'sd32767, -16'sd1, 1'b1);
    send_frame(-16'sd32768, 16'sd32767, 1'b0);
    send_frame(16'sd32767, -16'sd32768, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);
    drain_and_settle();
    write_reg(CFG_IDX_STEREO, 17'd1);
    send_frame(-16'sd32768, -16'sd32768, 1'b1);
    send_frame(16'sd32767, 16'sd32767, 1'b0);
    send_frame(16'sd32767, -16'sd32768, 1'b0);
    send_frame(-16'sd3, 16'sd0, 1'b0);
    send_frame(-16'sd32768, 16'sd32767, 1'b0);
    drain_and_settle();
  endtask

  task automatic test_rate_limits();
    write_reg(CFG_IDX_STEREO, 17'd0);
    write_reg(CFG_IDX_RATE, RATE_MIN);
    send_frame(16'sd100, 16'sd0, 1'b1);
    send_frame(-16'sd20000, 16'sd0, 1'b0);
    send_frame(16'sd32767, 16'sd0, 1'b0);
    drain_and_settle();
    write_reg(CFG_IDX_RATE, RATE_MAX);
    send_frame(-16'sd32768, 16'sd0, 1'b1);
    send_frame(16'sd12345, 16'sd0, 1'b0);
    send_frame(-16'sd2, 16'sd0, 1'b0);
    send_frame(16'sd32767, 16'sd0, 1'b0);
    drain_and_settle();
    // out-of-range rates must leave 44.1 kHz in place
    write_reg(CFG_IDX_RATE, 17'd44100);
    write_reg(CFG_IDX_RATE, 17'd7999);
    write_reg(CFG_IDX_RATE, 17'd96001);
    write_reg(CFG_IDX_RATE, 17'd0);
    write_reg(CFG_IDX_RATE, 17'h1FFFF);
    send_frame(16'sd5000, 16'sd0, 1'b0);
    send_frame(-16'sd5000, 16'sd0, 1'b0);
    send_frame(16'sd30000, 16'sd0, 1'b0);
    drain_and_settle();
  endtask

  task automatic test_volume_and_index();
    write_reg(CFG_IDX_VOLUME, 17'd0);
    send_frame(16'sd32767, 16'sd0, 1'b1);
    drain_and_settle();
    write_reg(CFG_IDX_VOLUME, 17'd127);
    send_frame(-16'sd32768, 16'sd0, 1'b1);
    drain_and_settle();
    write_reg(CFG_IDX_VOLUME, 17'd178);
    send_frame(-16'sd32767, 16'sd0, 1'b1);
    drain_and_settle();
    write_reg(CFG_IDX_SPARE, 17'h1FFFF);
    send_frame(16'sd32767, 16'sd0, 1'b0);
    drain_and_settle();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_IDX_RATE, RATE_MIN);
    write_reg(CFG_IDX_VOLUME, 17'd100);
    write_reg(CFG_IDX_STEREO, 17'd0);
    send_gaps_on = 1'b0;
    hold_request = LONG_HOLD_CYCLES;
    for (int i = 0; i < BURST_FRAMES; i++) send_random_frame();
    drain_and_settle();
    send_gaps_on = 1'b1;
  endtask

  task automatic test_random_streams();
    logic [CFG_W-1:0] rate;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: rate = RATE_MIN;
        1: rate = RATE_MAX;
        2: rate = 17'd44100;
        default: rate = CFG_W'($urandom_range(int'(RATE_MIN), int'(RATE_MAX)));
      endcase
      write_reg(CFG_IDX_RATE, rate);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_RATE, $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 7999))
                                                   : CFG_W'($urandom_range(96001, 131071)));
      end
      write_reg(CFG_IDX_VOLUME, CFG_W'($urandom_range(0, 127)));
      write_reg(CFG_IDX_STEREO, CFG_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) write_reg(CFG_IDX_SPARE, CFG_W'($urandom));
      send_gaps_on = (p % 4 == 0) || (p % 4 == 3);
      recv_gaps_on = (p % 4 == 0) || (p % 4 == 2);
      for (int i = 0; i < PHASE_FRAMES; i++) send_random_frame();
      drain_and_settle();
    end
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  // output ready, with an occasional long hold
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      gap = recv_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transaction: out_word %h last %b", out_ch.out_word, out_ch.last);
        end
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_word !== want.word || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word %0d: out_word expected %h got %h, last expected %b got %b",
                     words_checked, want.word, out_ch.out_word, want.last, out_ch.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d words outstanding",
               STALL_LIMIT, expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_IDX_RATE;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    in_ch.restart      <= 1'b0;
    out_ch.ready       <= 1'b0;
    mismatches    = 0;
    frames_sent   = 0;
    words_checked = 0;
    cfg_writes    = 0;
    idle_cycles   = 0;
    hold_request  = 0;
    send_gaps_on  = 1'b1;
    recv_gaps_on  = 1'b1;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_sample_extremes();
    test_rate_limits();
    test_volume_and_index();
    test_backpressure();
    test_random_streams();

    drain_and_settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0d expected words never arrived", expected_beats.size());
      mismatches += expected_beats.size();
    end
    $display("covered %0d frames, %0d output words and %0d register writes",
             frames_sent, words_checked, cfg_writes);
    $display("mono and stereo, rates %0d to %0d Hz, full-scale samples, stalls on both sides",
             RATE_MIN, RATE_MAX);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[linear_interp_resampler_core.f]
+incdir+design
design/lir_pkg.sv
design/lir_in_if.sv
design/lir_out_if.sv
design/lir_cfg.sv
design/lir_ctrl.sv
design/lir_dp.sv
design/linear_interp_resampler_core.sv
tb/sv/tb_linear_interp_resampler_core.sv
